@@ rtl/core/gf256_pkg.sv @@
// Package with the GF(2^8) operation codes and the constant log and antilog tables.
package gf256_pkg;

    // Field reduction constant for x^8+x^4+x^3+x^2+1, and the multiplicative order.
    localparam logic [7:0] GF_FEEDBACK = 8'h1d;
    localparam logic [7:0] GF_ORDER    = 8'hff;

    // Operation codes carried with each transaction.
    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_RECIP = 3'd4,
        OP_NEG   = 3'd5,
        OP_LOG   = 3'd6,
        OP_EXP   = 3'd7
    } t_op;

    typedef logic [7:0]            t_byte;
    typedef logic [255:0][7:0]     t_table;

    // Multiply a field element by alpha.
    function automatic t_byte gf_xtime(input t_byte v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_FEEDBACK : 8'h00);
    endfunction

    // Antilog table: entry e holds alpha^e, with alpha^255 = 1.
    function automatic t_table build_exp_table();
        t_table t;
        t_byte  v;
        v = 8'h01;
        for (int i = 0; i < 256; i++) begin
            t[i] = v;
            v    = gf_xtime(v);
        end
        return t;
    endfunction

    // Log table: entry x holds log_alpha(x); zero maps to 255.
    function automatic t_table build_log_table();
        t_table t;
        t_byte  v;
        t    = '0;
        t[0] = GF_ORDER;
        v    = 8'h01;
        for (int i = 0; i < 255; i++) begin
            t[v] = i[7:0];
            v    = gf_xtime(v);
        end
        return t;
    endfunction

    // Tables are built at elaboration and become constant logic.
    localparam t_table EXP_TABLE = build_exp_table();
    localparam t_table LOG_TABLE = build_log_table();

endpackage

@@ rtl/core/gf256_arith_unit.sv @@
// GF(2^8) arithmetic unit over polynomial 0x11d: four-stage pipeline with table lookups.
// A transaction accepted at one clock edge passes the stage 1, stage 2 and stage 3 registers
// and the output register, then shows its result on o_result with o_valid high.
// Throughput: one transaction per cycle; busy is never raised, since the receiver
// cannot stall and each stage holds at most one table lookup or one modulo-255 add.
// Reset (i_rst_n, synchronous, active low) drops every in-flight transaction.
module gf256_arith_unit
    import gf256_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_operation,
    input  logic [7:0] i_operand_a,
    input  logic [7:0] i_operand_b,
    output logic [7:0] o_result,
    output logic       o_valid
);

    // Stage 1 registers: captured operands.
    logic       r_s1_valid;
    t_op        r_s1_op;
    t_byte      r_s1_a;
    t_byte      r_s1_b;

    // Stage 2 registers: logs, zero flags and the directly computed value.
    logic       r_s2_valid;
    t_op        r_s2_op;
    t_byte      r_s2_la;
    t_byte      r_s2_lb;
    logic       r_s2_za;
    logic       r_s2_zb;
    t_byte      r_s2_direct;
    t_byte      n_s2_direct;

    // Stage 3 registers: antilog index or bypass value.
    logic       r_s3_valid;
    logic       r_s3_bypass;
    logic       r_s3_zero;
    t_byte      r_s3_idx;
    t_byte      r_s3_direct;
    logic       n_s3_bypass;
    logic       n_s3_zero;
    t_byte      n_s3_idx;

    // Stage 4 registers: the output.
    logic       r_out_valid;
    t_byte      r_out_result;
    t_byte      n_out_result;

    // Exponent arithmetic modulo 255.
    logic [8:0] sum_l;
    logic [8:0] diff_l;
    t_byte      idx_mul;
    t_byte      idx_div;
    t_byte      idx_recip;

    // The pipeline never stalls.
    assign busy = 1'b0;

    // Valid bits travel down the pipeline and are cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= start && !busy;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    // Stage 2 logic: log lookups and the XOR or pass-through value.
    always_comb begin
        case (r_s1_op)
            OP_ADD, OP_SUB: n_s2_direct = r_s1_a ^ r_s1_b;
            OP_LOG:         n_s2_direct = LOG_TABLE[r_s1_a];
            default:        n_s2_direct = r_s1_a;
        endcase
    end

    // Stage 3 logic: form the antilog index for the log-domain operations.
    assign sum_l     = {1'b0, r_s2_la} + {1'b0, r_s2_lb};
    assign diff_l    = {1'b0, r_s2_la} - {1'b0, r_s2_lb};
    assign idx_mul   = (sum_l >= {1'b0, GF_ORDER}) ? 8'(sum_l - {1'b0, GF_ORDER})
                                                   : sum_l[7:0];
    assign idx_div   = diff_l[8] ? (diff_l[7:0] + GF_ORDER) : diff_l[7:0];
    assign idx_recip = (r_s2_la == 8'h00) ? 8'h00 : (GF_ORDER - r_s2_la);

    always_comb begin
        n_s3_bypass = 1'b0;
        n_s3_zero   = 1'b0;
        n_s3_idx    = 8'h00;
        case (r_s2_op)
            OP_MUL: begin
                n_s3_zero = r_s2_za || r_s2_zb;
                n_s3_idx  = idx_mul;
            end
            OP_DIV: begin
                n_s3_zero = r_s2_za || r_s2_zb;
                n_s3_idx  = idx_div;
            end
            OP_RECIP: begin
                n_s3_zero = r_s2_za;
                n_s3_idx  = idx_recip;
            end
            OP_EXP: begin
                // alpha^255 equals alpha^0.
                n_s3_idx = (r_s2_direct == GF_ORDER) ? 8'h00 : r_s2_direct;
            end
            default: begin
                n_s3_bypass = 1'b1;
            end
        endcase
    end

    // Stage 4 logic: antilog lookup and final selection.
    always_comb begin
        if (r_s3_bypass) begin
            n_out_result = r_s3_direct;
        end else if (r_s3_zero) begin
            n_out_result = 8'h00;
        end else begin
            n_out_result = EXP_TABLE[r_s3_idx];
        end
    end

    // Payload registers of all stages.
    always_ff @(posedge i_clk) begin
        r_s1_op      <= t_op'(i_operation);
        r_s1_a       <= i_operand_a;
        r_s1_b       <= i_operand_b;

        r_s2_op      <= r_s1_op;
        r_s2_la      <= LOG_TABLE[r_s1_a];
        r_s2_lb      <= LOG_TABLE[r_s1_b];
        r_s2_za      <= (r_s1_a == 8'h00);
        r_s2_zb      <= (r_s1_b == 8'h00);
        r_s2_direct  <= n_s2_direct;

        r_s3_bypass  <= n_s3_bypass;
        r_s3_zero    <= n_s3_zero;
        r_s3_idx     <= n_s3_idx;
        r_s3_direct  <= r_s2_direct;

        r_out_result <= n_out_result;
    end

    assign o_result = r_out_result;
    assign o_valid  = r_out_valid;

    // A result strobe always stems from a transaction accepted at the input of the pipeline.
    a_strobe_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 4))
        else $error("result strobe without matching transaction");

    // Multiplying by a zero first operand yields zero.
    a_mul_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_operation, 4) == OP_MUL && $past(i_operand_a, 4) == 8'h00)
        |-> (o_result == 8'h00))
        else $error("multiply by zero gave a nonzero result");

    // Log returns 255 exactly when its operand is zero.
    a_log_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_operation, 4) == OP_LOG)
        |-> ((o_result == 8'hff) == ($past(i_operand_a, 4) == 8'h00)))
        else $error("log result 255 does not match a zero operand");

    // Add returns the XOR of the operands.
    a_add_xor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_operation, 4) == OP_ADD)
        |-> (o_result == ($past(i_operand_a, 4) ^ $past(i_operand_b, 4))))
        else $error("add result differs from operand XOR");

endmodule

@@ dv/gf256_arith_unit_tb.sv @@
// Self-checking testbench for the GF(2^8) arithmetic unit: directed table and random stimulus.
module gf256_arith_unit_tb;
    import gf256_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1000;
    localparam int QUIET_LIMIT    = 1000;
    localparam int REPORT_LIMIT   = 10;
    localparam int SETTLE_CYCLES  = 10;

    // One row of the directed stimulus table.
    typedef struct {
        t_op   op;
        t_byte a;
        t_byte b;
        bit    known;
        t_byte value;
    } t_vector;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    t_op   i_operation = OP_ADD;
    t_byte i_operand_a = '0;
    t_byte i_operand_b = '0;
    t_byte o_result;
    logic  o_valid;

    // Expectation attached to the transaction currently driven.
    bit    drive_known = 1'b0;
    t_byte drive_value = '0;

    bit    took_item = 1'b0;
    t_byte expected_results[$];
    int    mismatch_count = 0;
    int    quiet_cycles = 0;
    int    burst_left = 0;

    // Powers of alpha and discrete logs, built once at the start of the run.
    t_byte alpha_power[256];
    t_byte alpha_log[256];

    // Rows with a typed-in result are the extremes and the special cases.
    t_vector directed_rows[25] = '{
        '{OP_ADD,   8'h00, 8'h00, 1'b1, 8'h00},
        '{OP_ADD,   8'hff, 8'h0f, 1'b1, 8'hf0},
        '{OP_SUB,   8'hff, 8'hff, 1'b1, 8'h00},
        '{OP_SUB,   8'h5a, 8'h3c, 1'b0, 8'h00},
        '{OP_MUL,   8'h00, 8'hb7, 1'b1, 8'h00},
        '{OP_MUL,   8'hc3, 8'h00, 1'b1, 8'h00},
        '{OP_MUL,   8'hff, 8'hff, 1'b0, 8'h00},
        '{OP_MUL,   8'h02, 8'h80, 1'b1, 8'h1d},
        '{OP_DIV,   8'h57, 8'h00, 1'b1, 8'h00},
        '{OP_DIV,   8'hff, 8'h01, 1'b1, 8'hff},
        '{OP_DIV,   8'h00, 8'hff, 1'b1, 8'h00},
        '{OP_DIV,   8'h8e, 8'h3c, 1'b0, 8'h00},
        '{OP_RECIP, 8'h00, 8'hff, 1'b1, 8'h00},
        '{OP_RECIP, 8'h01, 8'h00, 1'b1, 8'h01},
        '{OP_RECIP, 8'hff, 8'h5c, 1'b0, 8'h00},
        '{OP_RECIP, 8'h02, 8'ha3, 1'b0, 8'h00},
        '{OP_NEG,   8'h00, 8'hff, 1'b1, 8'h00},
        '{OP_NEG,   8'hff, 8'h00, 1'b1, 8'hff},
        '{OP_LOG,   8'h00, 8'h77, 1'b1, 8'hff},
        '{OP_LOG,   8'h01, 8'hff, 1'b1, 8'h00},
        '{OP_LOG,   8'h02, 8'h00, 1'b1, 8'h01},
        '{OP_LOG,   8'hff, 8'h12, 1'b0, 8'h00},
        '{OP_EXP,   8'h00, 8'hff, 1'b1, 8'h01},
        '{OP_EXP,   8'hff, 8'h00, 1'b1, 8'h01},
        '{OP_EXP,   8'hfe, 8'h81, 1'b0, 8'h00}
    };

    gf256_arith_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_result    (o_result),
        .o_valid     (o_valid)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shift left by one and reduce by x^8+x^4+x^3+x^2+1.
    function automatic t_byte mul_by_alpha(input t_byte v);
        t_byte shifted;
        shifted = {v[6:0], 1'b0};
        if (v[7]) begin
            shifted = shifted ^ 8'h1d;
        end
        return shifted;
    endfunction

    // Shift-and-add product, independent of the log tables.
    function automatic t_byte field_product(input t_byte a, input t_byte b);
        t_byte acc;
        t_byte term;
        acc  = '0;
        term = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ term;
            end
            term = mul_by_alpha(term);
        end
        return acc;
    endfunction

    // Zero and one are their own inverses; the rest go through the tables.
    function automatic t_byte field_inverse(input t_byte x);
        if (x <= 8'd1) begin
            return x;
        end
        return alpha_power[8'(9'd255 - {1'b0, alpha_log[x]})];
    endfunction

    // Expected result byte for one transaction.
    function automatic t_byte gf_op_result(input t_op op, input t_byte a, input t_byte b);
        case (op)
            OP_ADD, OP_SUB: return a ^ b;
            OP_MUL:         return field_product(a, b);
            OP_DIV:         return field_product(a, field_inverse(b));
            OP_RECIP:       return field_inverse(a);
            OP_NEG:         return a;
            OP_LOG:         return alpha_log[a];
            default:        return alpha_power[a];
        endcase
    endfunction

    // Operands lean toward zero, one and all-ones.
    function automatic t_byte pick_operand();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'hff;
            default: return t_byte'($urandom);
        endcase
    endfunction

    task automatic note_mismatch(input string what, input t_byte want, input t_byte got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("tb: %s mismatch: expected %02h, got %02h at %0t",
                     what, want, got, $realtime);
        end
    endtask

    // Sample at the rising edge: record accepted transactions and check results.
    always @(posedge i_clk) begin : monitor
        t_byte want;
        took_item = 1'b0;
        if (i_rst_n) begin
            if (start && busy === 1'b0) begin
                took_item = 1'b1;
                if (drive_known) begin
                    expected_results.push_back(drive_value);
                end else begin
                    expected_results.push_back(
                        gf_op_result(i_operation, i_operand_a, i_operand_b));
                end
            end
            if (o_valid === 1'b1) begin
                if (expected_results.size() == 0) begin
                    note_mismatch("unexpected result", 8'h00, o_result);
                end else begin
                    want = expected_results.pop_front();
                    if (o_result !== want) begin
                        note_mismatch("result", want, o_result);
                    end
                end
            end else if (o_valid !== 1'b0) begin
                note_mismatch("unknown strobe", 8'h00, o_result);
            end
        end
        // Watchdog on cycles where no transaction moves in either direction.
        if (took_item || o_valid === 1'b1) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Drive one transaction at the falling edge and hold it until accepted.
    task automatic send_item(input t_op op, input t_byte a, input t_byte b,
                             input bit known, input t_byte value);
        i_operation = op;
        i_operand_a = a;
        i_operand_b = b;
        drive_known = known;
        drive_value = value;
        start       = 1'b1;
        do begin
            @(negedge i_clk);
        end while (!took_item);
    endtask

    // Bursts of random length separated by random gaps, sometimes none.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
            start       = 1'b0;
            i_operation = t_op'($urandom_range(0, 7));
            i_operand_a = t_byte'($urandom);
            i_operand_b = t_byte'($urandom);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Wait with start low until every outstanding result has come back.
    task automatic drain_results();
        start = 1'b0;
        while (expected_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin : stimulus
        t_byte v;
        v = 8'h01;
        for (int i = 0; i < 256; i++) begin
            alpha_power[i] = v;
            if (i < 255) begin
                alpha_log[v] = 8'(i);
            end
            v = mul_by_alpha(v);
        end
        alpha_log[0] = 8'hff;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table: extremes, every operation and the special cases.
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                      directed_rows[i].known, directed_rows[i].value);
            pace_sender();
        end

        // Random transactions, with one full drain in the middle.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                drain_results();
            end
            send_item(t_op'($urandom_range(0, 7)), pick_operand(), pick_operand(),
                      1'b0, 8'h00);
            pace_sender();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ gf256_arith_unit.f @@
rtl/core/gf256_pkg.sv
rtl/core/gf256_arith_unit.sv
dv/gf256_arith_unit_tb.sv
